FILE: hdl/assert_macros.svh
// assertion macros shared by the maze search rtl
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define MDFS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset as well
`define MDFS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/mdfs_pkg.sv
// types, constants and register codes for the maze depth-first search block
// no dependencies
package mdfs_pkg;

  localparam int DEF_MAX_ROWS          = 32;
  localparam int DEF_MAX_COLS          = 32;
  localparam int DEF_POINT_STACK_DEPTH = 4096;

  localparam int COORD_W = 5;
  localparam int DEPTH_W = 11;
  localparam int BOUND_W = 6;
  localparam int INDEX_W = 10;
  localparam int LEN_W   = 11;
  localparam int KIND_W  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_COL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_ROW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_USE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_USE  = 3'd5;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [DEPTH_W-1:0] depth;
  } point_t;

  localparam int POINT_W = $bits(point_t);

  typedef struct packed {
    logic [COORD_W-1:0] start_col;
    logic [COORD_W-1:0] start_row;
    logic [COORD_W-1:0] dest_col;
    logic [COORD_W-1:0] dest_row;
    logic [BOUND_W-1:0] rows_in_use;
    logic [BOUND_W-1:0] cols_in_use;
  } cfg_t;

endpackage

FILE: hdl/mdfs_if.sv
// request and response channel interfaces for the maze search block
// depends on mdfs_pkg
interface mdfs_req_if;
  import mdfs_pkg::*;
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [COORD_W-1:0] cell_row;
  logic [COORD_W-1:0] cell_col;
  logic               cell_open;
  logic [INDEX_W-1:0] path_index;
  modport source (output valid, kind, cell_row, cell_col, cell_open, path_index, input ready);
  modport sink (input valid, kind, cell_row, cell_col, cell_open, path_index, output ready);
endinterface

interface mdfs_rsp_if;
  import mdfs_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [LEN_W-1:0]   path_length;
  logic [COORD_W-1:0] point_col;
  logic [COORD_W-1:0] point_row;
  modport source (output valid, found, path_length, point_col, point_row, input ready);
  modport sink (input valid, found, path_length, point_col, point_row, output ready);
endinterface

FILE: hdl/mdfs_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
module mdfs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/mdfs_ctrl.sv
// search sequencer with maze, visited, point stack and path memories
// depends on mdfs_pkg, mdfs_if, mdfs_ram and assert_macros.svh
`include "assert_macros.svh"
module mdfs_ctrl #(
  parameter int MAX_ROWS          = mdfs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS          = mdfs_pkg::DEF_MAX_COLS,
  parameter int POINT_STACK_DEPTH = mdfs_pkg::DEF_POINT_STACK_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  mdfs_pkg::cfg_t  cfg,
  mdfs_req_if.sink        req,
  mdfs_rsp_if.source      rsp
);
  import mdfs_pkg::*;

  localparam int CELLS    = MAX_ROWS * MAX_COLS;
  localparam int CELL_W   = $clog2(CELLS);
  localparam int PTOP_W   = $clog2(POINT_STACK_DEPTH + 1);
  localparam int PADDR_W  = $clog2(POINT_STACK_DEPTH);
  localparam int PATH_W   = $clog2(CELLS + 1);
  localparam int LIM_W    = 9;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD_WT  = 4'd1;
  localparam logic [3:0] S_CLR    = 4'd2;
  localparam logic [3:0] S_POP_RD = 4'd3;
  localparam logic [3:0] S_POP_WT = 4'd4;
  localparam logic [3:0] S_CHK_RD = 4'd5;
  localparam logic [3:0] S_CHK_EV = 4'd6;
  localparam logic [3:0] S_NB_RD  = 4'd7;
  localparam logic [3:0] S_NB_EV  = 4'd8;
  localparam logic [3:0] S_RL_RD  = 4'd9;
  localparam logic [3:0] S_RL_WT  = 4'd10;
  localparam logic [3:0] S_RT_RD  = 4'd11;
  localparam logic [3:0] S_RT_EV  = 4'd12;
  localparam logic [3:0] S_FINISH = 4'd13;

  logic [3:0]         state;
  logic [CELL_W-1:0]  clr_addr;
  point_t             cur;
  logic [1:0]         nb;
  logic               pushed;
  logic [PTOP_W-1:0]  ptop;
  logic [PATH_W-1:0]  path_top;
  logic               found_flag;
  logic [DEPTH_W-1:0] lim;
  logic [INDEX_W-1:0] rd_idx;

  logic               out_valid;
  logic               out_found;
  logic [LEN_W-1:0]   out_len;
  logic [COORD_W-1:0] out_col;
  logic [COORD_W-1:0] out_row;

  logic [LIM_W-1:0]   row_lim;
  logic [LIM_W-1:0]   col_lim;
  logic [BOUND_W-1:0] nb_col;
  logic [BOUND_W-1:0] nb_row;
  logic               nb_inb;
  logic               cur_inb;
  logic               nb_pass;
  logic               cur_pass;
  logic [CELL_W-1:0]  cur_addr;
  logic [CELL_W-1:0]  nb_addr;
  logic [LEN_W-1:0]   len;
  logic               accept;
  logic               slot_free;

  logic               open_we;
  logic [CELL_W-1:0]  open_waddr;
  logic               open_rd;
  logic               vis_we;
  logic [CELL_W-1:0]  vis_waddr;
  logic               vis_wd;
  logic               vis_rd;
  logic [CELL_W-1:0]  map_raddr;
  logic               ps_we;
  logic [PADDR_W-1:0] ps_raddr;
  logic [POINT_W-1:0] ps_rdata;
  point_t             ps_pt;
  logic               pa_we;
  logic [CELL_W-1:0]  pa_raddr;
  logic [POINT_W-1:0] pa_rdata;
  point_t             pa_pt;

  function automatic logic [CELL_W-1:0] cell_of(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
    cell_of = CELL_W'(32'(r) * MAX_COLS + 32'(c));
  endfunction

  assign row_lim = (LIM_W'(cfg.rows_in_use) > LIM_W'(MAX_ROWS)) ? LIM_W'(MAX_ROWS)
                                                                : LIM_W'(cfg.rows_in_use);
  assign col_lim = (LIM_W'(cfg.cols_in_use) > LIM_W'(MAX_COLS)) ? LIM_W'(MAX_COLS)
                                                                : LIM_W'(cfg.cols_in_use);

  always_comb begin
    nb_col = BOUND_W'(cur.col);
    nb_row = BOUND_W'(cur.row);
    unique case (nb)
      2'd0: nb_col = BOUND_W'(cur.col) - 1'b1;
      2'd1: nb_col = BOUND_W'(cur.col) + 1'b1;
      2'd2: nb_row = BOUND_W'(cur.row) - 1'b1;
      default: nb_row = BOUND_W'(cur.row) + 1'b1;
    endcase
  end

  assign nb_inb   = (LIM_W'(nb_col) < col_lim) && (LIM_W'(nb_row) < row_lim);
  assign cur_inb  = (LIM_W'(cur.col) < col_lim) && (LIM_W'(cur.row) < row_lim);
  assign cur_addr = cell_of(cur.row, cur.col);
  assign nb_addr  = cell_of(nb_row[COORD_W-1:0], nb_col[COORD_W-1:0]);
  assign cur_pass = cur_inb && open_rd && !vis_rd;
  assign nb_pass  = nb_inb && open_rd && !vis_rd;
  assign len      = found_flag ? LEN_W'(path_top) : '0;

  assign slot_free = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && slot_free;
  assign accept    = req.valid && req.ready;

  assign ps_pt = point_t'(ps_rdata);
  assign pa_pt = point_t'(pa_rdata);

  // memory port steering
  assign open_we    = accept && (req.kind == KIND_LOAD) && (32'(req.cell_row) < MAX_ROWS)
                      && (32'(req.cell_col) < MAX_COLS);
  assign open_waddr = cell_of(req.cell_row, req.cell_col);
  assign map_raddr  = (state == S_CHK_RD) ? cur_addr : nb_addr;
  assign ps_raddr   = PADDR_W'(ptop - 1'b1);
  assign ps_we      = (state == S_NB_EV) && nb_pass && (32'(ptop) < POINT_STACK_DEPTH);
  assign pa_raddr   = (state == S_IDLE) ? CELL_W'(req.path_index) : CELL_W'(path_top - 1'b1);
  assign pa_we      = (state == S_CHK_EV) && cur_pass && (32'(path_top) < CELLS);

  always_comb begin
    vis_we    = 1'b0;
    vis_waddr = cur_addr;
    vis_wd    = 1'b0;
    priority if (state == S_CLR) begin
      vis_we    = 1'b1;
      vis_waddr = clr_addr;
    end else if (state == S_CHK_EV && cur_pass) begin
      vis_we = 1'b1;
      vis_wd = 1'b1;
    end else if (state == S_RT_EV && pa_pt.depth >= lim) begin
      vis_we    = 1'b1;
      vis_waddr = cell_of(pa_pt.row, pa_pt.col);
    end else begin
      vis_we = 1'b0;
    end
  end

  mdfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_open (
    .clk(clk), .we(open_we), .waddr(open_waddr), .wdata(req.cell_open),
    .raddr(map_raddr), .rdata(open_rd)
  );

  mdfs_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wd),
    .raddr(map_raddr), .rdata(vis_rd)
  );

  mdfs_ram #(.WIDTH(POINT_W), .DEPTH(POINT_STACK_DEPTH)) u_point_stack (
    .clk(clk), .we(ps_we), .waddr(PADDR_W'(ptop)),
    .wdata({nb_col[COORD_W-1:0], nb_row[COORD_W-1:0], DEPTH_W'(cur.depth + 1'b1)}),
    .raddr(ps_raddr), .rdata(ps_rdata)
  );

  mdfs_ram #(.WIDTH(POINT_W), .DEPTH(CELLS)) u_path_stack (
    .clk(clk), .we(pa_we), .waddr(CELL_W'(path_top)), .wdata(cur),
    .raddr(pa_raddr), .rdata(pa_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ptop       <= '0;
      path_top   <= '0;
      found_flag <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.kind == KIND_SEARCH) begin
              clr_addr <= '0;
              state    <= S_CLR;
            end else if (req.kind == KIND_READ) begin
              rd_idx <= req.path_index;
              state  <= S_RD_WT;
            end else begin
              out_valid <= 1'b1;
              out_found <= found_flag;
              out_len   <= len;
              out_col   <= '0;
              out_row   <= '0;
            end
          end
        end
        S_RD_WT: begin
          out_valid <= 1'b1;
          out_found <= found_flag;
          out_len   <= len;
          if (LEN_W'(rd_idx) < len) begin
            out_col <= pa_pt.col;
            out_row <= pa_pt.row;
          end else begin
            out_col <= '0;
            out_row <= '0;
          end
          state <= S_IDLE;
        end
        S_CLR: begin
          if (32'(clr_addr) == CELLS - 1) begin
            cur        <= {cfg.start_col, cfg.start_row, DEPTH_W'(1)};
            ptop       <= '0;
            path_top   <= '0;
            found_flag <= 1'b0;
            state      <= S_CHK_RD;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        S_POP_RD: begin
          if (ptop == '0) begin
            state <= S_FINISH;
          end else begin
            ptop  <= ptop - 1'b1;
            state <= S_POP_WT;
          end
        end
        S_POP_WT: begin
          cur   <= ps_pt;
          state <= S_CHK_RD;
        end
        S_CHK_RD: state <= S_CHK_EV;
        S_CHK_EV: begin
          if (!cur_pass) begin
            state <= S_POP_RD;
          end else begin
            if (32'(path_top) < CELLS) begin
              path_top <= path_top + 1'b1;
            end
            if (cur.col == cfg.dest_col && cur.row == cfg.dest_row) begin
              found_flag <= 1'b1;
              state      <= S_FINISH;
            end else begin
              nb     <= 2'd0;
              pushed <= 1'b0;
              state  <= S_NB_RD;
            end
          end
        end
        S_NB_RD: state <= S_NB_EV;
        S_NB_EV: begin
          if (nb_pass) begin
            pushed <= 1'b1;
          end
          if (ps_we) begin
            ptop <= ptop + 1'b1;
          end
          if (nb == 2'd3) begin
            state <= (pushed || nb_pass) ? S_POP_RD : S_RL_RD;
          end else begin
            nb    <= nb + 1'b1;
            state <= S_NB_RD;
          end
        end
        S_RL_RD: begin
          // empty point stack retracts the whole path
          if (ptop == '0) begin
            lim   <= '0;
            state <= S_RT_RD;
          end else begin
            state <= S_RL_WT;
          end
        end
        S_RL_WT: begin
          lim   <= ps_pt.depth;
          state <= S_RT_RD;
        end
        S_RT_RD: begin
          state <= (path_top == '0) ? S_POP_RD : S_RT_EV;
        end
        S_RT_EV: begin
          if (pa_pt.depth >= lim) begin
            path_top <= path_top - 1'b1;
            state    <= S_RT_RD;
          end else begin
            state <= S_POP_RD;
          end
        end
        S_FINISH: begin
          out_valid <= 1'b1;
          out_found <= found_flag;
          out_len   <= len;
          out_col   <= '0;
          out_row   <= '0;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.found       = out_found;
  assign rsp.path_length = out_len;
  assign rsp.point_col   = out_col;
  assign rsp.point_row   = out_row;

  `MDFS_ASSERT(a_accept_idle, (req.valid && req.ready) |-> (state == S_IDLE), "transfer outside idle")
  `MDFS_ASSERT(a_found_path, found_flag |-> (path_top != '0), "found with empty path")
  `MDFS_ASSERT(a_ptop_bound, 32'(ptop) <= POINT_STACK_DEPTH, "point stack overrun")
  `MDFS_ASSERT(a_path_bound, 32'(path_top) <= CELLS, "path stack overrun")
  `MDFS_ASSERT(a_result_slot, (state == S_FINISH || state == S_RD_WT) |-> !out_valid || rsp.ready,
               "result register busy at completion")
endmodule

FILE: hdl/maze_dfs_single_path.sv
// maze depth-first search: load and no-op items are answered from idle, read items
// after a read wait state; a search first clears the visited map cell by cell, then
// pops points, checks each one, scans its neighbors, retracts the path at dead ends
// one item in flight at a time; the next is accepted once the result register is free
// synchronous reset empties both stacks, clears found and loads default bounds
module maze_dfs_single_path #(
  parameter int MAX_ROWS          = mdfs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS          = mdfs_pkg::DEF_MAX_COLS,
  parameter int POINT_STACK_DEPTH = mdfs_pkg::DEF_POINT_STACK_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  mdfs_req_if.sink                            req,
  mdfs_rsp_if.source                          rsp,
  input  logic                                cfg_we,
  input  logic [mdfs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mdfs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mdfs_pkg::*;

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_col   <= '0;
      cfg.start_row   <= '0;
      cfg.dest_col    <= '0;
      cfg.dest_row    <= '0;
      cfg.rows_in_use <= BOUND_W'(32);
      cfg.cols_in_use <= BOUND_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_COL: cfg.start_col   <= cfg_data[COORD_W-1:0];
        REG_START_ROW: cfg.start_row   <= cfg_data[COORD_W-1:0];
        REG_DEST_COL:  cfg.dest_col    <= cfg_data[COORD_W-1:0];
        REG_DEST_ROW:  cfg.dest_row    <= cfg_data[COORD_W-1:0];
        REG_ROWS_USE:  cfg.rows_in_use <= cfg_data[BOUND_W-1:0];
        REG_COLS_USE:  cfg.cols_in_use <= cfg_data[BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  mdfs_ctrl #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLS(MAX_COLS),
    .POINT_STACK_DEPTH(POINT_STACK_DEPTH)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .req(req),
    .rsp(rsp)
  );
endmodule

FILE: bench/maze_path_checker.sv
// checker for the maze depth-first search block: mirrors maze, bounds and last search,
// predicts each response from request transfers and compares all its fields at once
// depends on mdfs_pkg and the channel interfaces in mdfs_if.sv
module maze_path_checker
  import mdfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  mdfs_req_if                   req,
  mdfs_rsp_if                   rsp,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  localparam int GRID_COLS = DEF_MAX_COLS;
  localparam int GRID_ROWS = DEF_MAX_ROWS;
  localparam int CELL_CNT  = GRID_ROWS * GRID_COLS;
  localparam int STACK_CNT = DEF_POINT_STACK_DEPTH;

  typedef struct packed {
    logic               found;
    logic [LEN_W-1:0]   path_length;
    logic [COORD_W-1:0] point_col;
    logic [COORD_W-1:0] point_row;
  } answer_t;

  logic [COORD_W-1:0] start_col, start_row, dest_col, dest_row;
  logic [BOUND_W-1:0] rows_use, cols_use;
  bit          open_cell [CELL_CNT];
  bit          seen_cell [CELL_CNT];
  int unsigned todo_col [STACK_CNT];
  int unsigned todo_row [STACK_CNT];
  int unsigned todo_dep [STACK_CNT];
  int unsigned todo_top;
  int unsigned trail_col [CELL_CNT];
  int unsigned trail_row [CELL_CNT];
  int unsigned trail_dep [CELL_CNT];
  int unsigned trail_top;
  bit          reached;
  answer_t     answer_q[$];

  function automatic bit can_enter(int unsigned c, int unsigned r);
    int unsigned lr, lc;
    lr = (rows_use > GRID_ROWS) ? GRID_ROWS : rows_use;
    lc = (cols_use > GRID_COLS) ? GRID_COLS : cols_use;
    if (c >= lc || r >= lr) return 0;
    return open_cell[r*GRID_COLS+c] && !seen_cell[r*GRID_COLS+c];
  endfunction

  function automatic int push_point(int unsigned c, int unsigned r, int unsigned d);
    if (!can_enter(c, r)) return 0;
    if (todo_top < STACK_CNT) begin
      todo_col[todo_top] = c;
      todo_row[todo_top] = r;
      todo_dep[todo_top] = d;
      todo_top++;
    end
    return 1;
  endfunction

  function automatic void unwind_trail();
    int unsigned floor_dep;
    floor_dep = (todo_top == 0) ? 0 : todo_dep[todo_top-1];
    while (trail_top > 0 && trail_dep[trail_top-1] >= floor_dep) begin
      trail_top--;
      seen_cell[trail_row[trail_top]*GRID_COLS+trail_col[trail_top]] = 0;
    end
  endfunction

  function automatic void walk_maze();
    int unsigned c, r, d;
    int moves;
    foreach (seen_cell[i]) seen_cell[i] = 0;
    trail_top = 0;
    reached = 0;
    todo_col[0] = 32'(start_col);
    todo_row[0] = 32'(start_row);
    todo_dep[0] = 1;
    todo_top = 1;
    while (todo_top > 0) begin
      todo_top--;
      c = todo_col[todo_top];
      r = todo_row[todo_top];
      d = todo_dep[todo_top];
      if (!can_enter(c, r)) continue;
      seen_cell[r*GRID_COLS+c] = 1;
      if (trail_top < CELL_CNT) begin
        trail_col[trail_top] = c;
        trail_row[trail_top] = r;
        trail_dep[trail_top] = d;
        trail_top++;
      end
      if (c == dest_col && r == dest_row) begin
        reached = 1;
        return;
      end
      moves = push_point(c - 1, r, d + 1);
      moves += push_point(c + 1, r, d + 1);
      moves += push_point(c, r - 1, d + 1);
      moves += push_point(c, r + 1, d + 1);
      if (moves == 0) unwind_trail();
    end
  endfunction

  function automatic answer_t predict_answer(logic [KIND_W-1:0] kind, logic [COORD_W-1:0] row,
                                             logic [COORD_W-1:0] col, logic open_bit,
                                             logic [INDEX_W-1:0] idx);
    answer_t a;
    int unsigned len;
    if (kind == KIND_LOAD) open_cell[row*GRID_COLS+col] = open_bit;
    else if (kind == KIND_SEARCH) walk_maze();
    len = reached ? trail_top : 0;
    a = '0;
    a.found = reached;
    a.path_length = LEN_W'(len);
    if (kind == KIND_READ && idx < len) begin
      a.point_col = COORD_W'(trail_col[idx]);
      a.point_row = COORD_W'(trail_row[idx]);
    end
    return a;
  endfunction

  always @(posedge clk) begin
    answer_t want, got;
    if (rst) begin
      start_col <= '0; start_row <= '0; dest_col <= '0; dest_row <= '0;
      rows_use <= BOUND_W'(32); cols_use <= BOUND_W'(32);
      foreach (open_cell[i]) open_cell[i] = 0;
      trail_top = 0;
      todo_top = 0;
      reached = 0;
      answer_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_COL: start_col <= cfg_data[COORD_W-1:0];
          REG_START_ROW: start_row <= cfg_data[COORD_W-1:0];
          REG_DEST_COL:  dest_col <= cfg_data[COORD_W-1:0];
          REG_DEST_ROW:  dest_row <= cfg_data[COORD_W-1:0];
          REG_ROWS_USE:  rows_use <= cfg_data;
          REG_COLS_USE:  cols_use <= cfg_data;
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        answer_q.push_back(predict_answer(req.kind, req.cell_row, req.cell_col,
                                          req.cell_open, req.path_index));
      if (rsp.valid && rsp.ready) begin
        got = {rsp.found, rsp.path_length, rsp.point_col, rsp.point_row};
        if (answer_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected response transfer: %p", got);
        end else begin
          want = answer_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("response mismatch: expected %p got %p", want, got);
          end
        end
      end
      pending <= answer_q.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
// top of the maze depth-first search bench: clock, reset, request stimulus in bursts,
// response stalls, configuration phases, watchdog and verdict
// depends on mdfs_pkg, mdfs_if.sv, maze_path_checker and maze_dfs_single_path
module tb_top;
  import mdfs_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;
  localparam int STALL_LIMIT = 400000;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int fail_count, pending;
  int burst_left, idle_cycles, rsp_phase;
  int cur_rows, cur_cols;

  mdfs_req_if req();
  mdfs_rsp_if rsp();

  maze_dfs_single_path dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  maze_path_checker checker_i (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern switches between four random modes: always ready, coin flip, rarely ready and periodic
  int rsp_tick;
  always @(posedge clk) begin
    rsp_tick <= rsp_tick + 1;
    if (rsp_tick % 300 == 0) rsp_phase <= $urandom_range(0, 3);
    case (rsp_phase)
      0: rsp.ready <= 1'b1;
      1: rsp.ready <= ($urandom_range(0, 1) == 1);
      2: rsp.ready <= ($urandom_range(0, 7) == 0);
      default: rsp.ready <= (rsp_tick % 5 != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("maze_dfs_single_path regression: fail");
      $finish;
    end
  end

  task automatic send_item(logic [KIND_W-1:0] kind, int row, int col, bit open_bit, int idx);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req.kind <= kind;
    req.cell_row <= COORD_W'(row);
    req.cell_col <= COORD_W'(col);
    req.cell_open <= open_bit;
    req.path_index <= INDEX_W'(idx);
    req.valid <= 1'b1;
    do @(posedge clk); while (!req.ready);
    burst_left--;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0 || (rsp.valid === 1'b1)) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    if (idx == REG_ROWS_USE) cur_rows = value;
    if (idx == REG_COLS_USE) cur_cols = value;
  endtask

  task automatic set_route(int sc, int sr, int dc, int dr);
    drain();
    write_reg(REG_START_COL, sc);
    write_reg(REG_START_ROW, sr);
    write_reg(REG_DEST_COL, dc);
    write_reg(REG_DEST_ROW, dr);
    cfg_we <= 1'b0;
  endtask

  task automatic set_bounds(int rows, int cols);
    drain();
    write_reg(REG_ROWS_USE, rows);
    write_reg(REG_COLS_USE, cols);
    cfg_we <= 1'b0;
  endtask

  int lim_r, lim_c, sc, sr, dc, dr;

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req.valid = 1'b0;
    req.kind = KIND_LOAD;
    req.cell_row = '0;
    req.cell_col = '0;
    req.cell_open = 1'b0;
    req.path_index = '0;
    rsp.ready = 1'b0;
    rsp_tick = 0;
    rsp_phase = 0;
    burst_left = 0;
    cur_rows = 32;
    cur_cols = 32;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // an 8 by 8 region is loaded and fenced by walls on row 8 and column 8
    set_bounds(8, 8);
    for (int r = 0; r < 8; r++)
      for (int c = 0; c < 8; c++)
        send_item(KIND_LOAD, r, c, $urandom_range(0, 9) < 6, 0);
    for (int c = 0; c < 9; c++) send_item(KIND_LOAD, 8, c, 0, 0);
    for (int r = 0; r < 8; r++) send_item(KIND_LOAD, r, 8, 0, 0);

    // start equals destination at the origin
    send_item(KIND_LOAD, 0, 0, 1, 0);
    send_item(KIND_SEARCH, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 0, 0, 1);
    send_item(KIND_READ, 0, 0, 0, 1023);
    send_item(KIND_NOP, 31, 31, 1, 1023);
    // start on a wall fails, then read after the failed search
    send_item(KIND_LOAD, 0, 0, 0, 0);
    send_item(KIND_SEARCH, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 0, 0, 0);
    send_item(KIND_LOAD, 0, 0, 1, 0);
    // open corridor along row 0 and column 7, far corner destination
    send_item(KIND_LOAD, 7, 7, 1, 0);
    for (int c = 1; c < 8; c++) send_item(KIND_LOAD, 0, c, 1, 0);
    for (int r = 1; r < 7; r++) send_item(KIND_LOAD, r, 7, 1, 0);
    set_route(0, 0, 7, 7);
    send_item(KIND_SEARCH, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 0, 0, 0);
    send_item(KIND_READ, 0, 0, 0, 7);
    send_item(KIND_READ, 0, 0, 0, 1023);
    // bounds above the grid clamp, zero bounds leave nothing, start outside bounds
    set_bounds(63, 63);
    send_item(KIND_SEARCH, 0, 0, 0, 0);
    set_bounds(0, 32);
    send_item(KIND_SEARCH, 0, 0, 0, 0);
    set_bounds(1, 1);
    set_route(0, 0, 0, 0);
    send_item(KIND_SEARCH, 0, 0, 0, 0);
    set_route(5, 0, 0, 0);
    send_item(KIND_SEARCH, 0, 0, 0, 0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: set_bounds(32, 32);
        1: set_bounds($urandom_range(2, 6), $urandom_range(2, 6));
        default: set_bounds($urandom_range(33, 63), $urandom_range(1, 12));
      endcase
      lim_r = (cur_rows > 8) ? 8 : cur_rows;
      lim_c = (cur_cols > 8) ? 8 : cur_cols;
      sc = $urandom_range(0, lim_c - 1);
      sr = $urandom_range(0, lim_r - 1);
      dc = $urandom_range(0, lim_c - 1);
      dr = $urandom_range(0, lim_r - 1);
      if (phase == 2) sc = 31;
      set_route(sc, sr, dc, dr);
      send_item(KIND_LOAD, sr, (sc > 7) ? 0 : sc, 1, 0);
      send_item(KIND_LOAD, dr, dc, 1, 0);
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: send_item(KIND_LOAD, $urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom_range(0, 9) < 7, $urandom_range(0, 1023));
          3: send_item(KIND_LOAD, $urandom_range(10, 31), $urandom_range(0, 31),
                       $urandom_range(0, 1), $urandom_range(0, 1023));
          4, 5: send_item(KIND_SEARCH, $urandom_range(0, 31), $urandom_range(0, 31),
                          $urandom_range(0, 1), $urandom_range(0, 1023));
          6, 7: send_item(KIND_READ, 0, 0, 0, $urandom_range(0, 40));
          8: send_item(KIND_READ, $urandom_range(0, 31), $urandom_range(0, 31),
                       $urandom_range(0, 1), $urandom_range(0, 1023));
          default: send_item(KIND_NOP, $urandom_range(0, 31), $urandom_range(0, 31),
                             $urandom_range(0, 1), $urandom_range(0, 1023));
        endcase
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("maze_dfs_single_path regression: pass");
    end else begin
      $display("maze_dfs_single_path regression: fail");
    end
    $finish;
  end

endmodule
